// ----- hw/rtl/svm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Input and result words, register indexes, command codes and the stage 1
// control word passed from the position stage to the mix datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

    // command codes of the input word
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_MIX   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 3;
    localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] REG_VOLUME_GAIN = 3'd1;
    localparam logic [2:0] REG_STEREO      = 3'd2;
    localparam logic [2:0] REG_LOOP        = 3'd3;
    localparam logic [2:0] REG_FRAME_COUNT = 3'd4;
    localparam int         CFG_DATA_W      = 24;

    localparam logic [23:0] PHASE_STEP_RST  = 24'd65536;
    localparam logic [15:0] VOLUME_GAIN_RST = 16'd4096;

    // position: Q17.16, integer part is the frame number
    localparam int POS_W   = 33;
    localparam int FRAME_W = 17;
    // word address of a read: frame * 2 + 1 at most
    localparam int RD_ADDR_W = FRAME_W + 1;

    // result queue
    localparam int                OUT_DEPTH = 8;
    localparam int                OUT_PTR_W = 3;
    localparam int                OCC_W     = 4;
    localparam logic [OCC_W-1:0]  OCC_FULL  = 4'd8;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        sample_addr;
        logic signed [15:0] sample_data;
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               still_playing;
    } out_t;

    // control word of a mix frame after the store read was issued
    typedef struct packed {
        logic               valid;
        logic               play;
        logic               stereo;
        logic               mono_odd;
        logic               l_ok;
        logic               r_ok;
        logic signed [15:0] bus_l;
        logic signed [15:0] bus_r;
    } s1_t;

endpackage

// ----- hw/rtl/sample_voice_mixer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_core: one PCM playback voice mixed into a stereo bus
// Sample store in two banks, Q17.16 play position, Q4.12 gain, saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry a command: write a sample word
//   into the store, start playback from frame zero, or mix one bus frame.
//   Only a mix word produces a result word on out_valid / out_stall; write
//   and start words (and the unused code) produce none.
//   Configuration (cfg_valid / cfg_ready, always ready) sets step, gain,
//   mono/stereo, looping and frame count; write it only while idle.
//   Throughput: one input word per cycle while in_stall is low. Position update is
//   done in the accept cycle, so back-to-back mix words see each other's position.
//   Result path: a mix result is visible once it has passed the store read,
//   the multiply register and the result queue.
//   The store is split into an even and an odd word bank so a stereo frame
//   reads both of its words in the same cycle.
//   Receiver stall: results collect in an 8-word queue; in_stall rises when
//   8 mix words are accepted and not yet delivered. Non-mix words take no credit
//   but are held too: nothing is accepted while the queue credit is out.
//   Reset: voice idle, position zero, registers at their defaults, queue
//   empty. The store is not cleared; unwritten words must not be played.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core #(
    parameter int STORE_WORDS = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  svm_pkg::in_t                      in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output svm_pkg::out_t                     out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [svm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int EVEN_DEPTH = (STORE_WORDS + 1) / 2;
    localparam int ODD_DEPTH  = STORE_WORDS / 2;
    localparam int EIDX_W     = $clog2(EVEN_DEPTH);
    localparam int OIDX_W     = $clog2(ODD_DEPTH);

    // configuration registers
    logic [23:0] phase_step_reg;
    logic [15:0] volume_gain_reg;
    logic        stereo_reg;
    logic        loop_reg;
    logic [16:0] frame_count_reg;

    // voice state
    logic [svm_pkg::POS_W-1:0]   pos_reg;
    logic [svm_pkg::POS_W-1:0]   pos_next;
    logic                        active_reg;
    logic                        active_next;

    logic                        in_acc;
    logic                        is_write;
    logic                        is_start;
    logic                        is_mix;
    logic                        end_hit;
    logic                        voice_wrap;
    logic                        voice_stop;
    logic [svm_pkg::POS_W-1:0]   pos_eff;
    logic [svm_pkg::POS_W:0]     pos_sum;
    logic [svm_pkg::POS_W-1:0]   pos_adv;
    logic [svm_pkg::FRAME_W-1:0] frame;
    logic [svm_pkg::FRAME_W-1:0] rd_idx;
    logic [svm_pkg::RD_ADDR_W-1:0] addr_l;
    logic [svm_pkg::RD_ADDR_W-1:0] addr_r;
    logic                        wr_ok;
    logic                        even_we;
    logic                        odd_we;
    logic                        rd_en;
    logic [15:0]                 even_data;
    logic [15:0]                 odd_data;

    svm_pkg::s1_t                s1_reg;
    svm_pkg::s1_t                s1_next;

    logic                        res_valid;
    svm_pkg::out_t               res_word;
    logic                        pop;
    logic [svm_pkg::OCC_W-1:0]   occ_reg;
    logic [svm_pkg::OCC_W-1:0]   occ_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= svm_pkg::PHASE_STEP_RST;
            volume_gain_reg <= svm_pkg::VOLUME_GAIN_RST;
            stereo_reg      <= 1'b0;
            loop_reg        <= 1'b0;
            frame_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                svm_pkg::REG_PHASE_STEP:  phase_step_reg  <= cfg_data[23:0];
                svm_pkg::REG_VOLUME_GAIN: volume_gain_reg <= cfg_data[15:0];
                svm_pkg::REG_STEREO:      stereo_reg      <= cfg_data[0];
                svm_pkg::REG_LOOP:        loop_reg        <= cfg_data[0];
                svm_pkg::REG_FRAME_COUNT: frame_count_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // credit for the result queue: mix words in flight plus queued results
    assign in_stall = (occ_reg == svm_pkg::OCC_FULL);
    assign in_acc   = in_valid && !in_stall;
    assign is_write = (in_word.cmd == svm_pkg::CMD_WRITE);
    assign is_start = (in_word.cmd == svm_pkg::CMD_START);
    assign is_mix   = (in_word.cmd == svm_pkg::CMD_MIX);

    // end of sound is checked before the frame plays
    assign end_hit    = (pos_reg[svm_pkg::POS_W-1:16] >= frame_count_reg);
    assign voice_wrap = active_reg && end_hit && loop_reg && (frame_count_reg != '0);
    assign voice_stop = active_reg && end_hit && !voice_wrap;
    assign pos_eff    = voice_wrap ? '0 : pos_reg;
    assign frame      = pos_eff[svm_pkg::POS_W-1:16];

    // advance with saturation at the top of the Q17.16 range
    assign pos_sum = {1'b0, pos_eff} + (svm_pkg::POS_W + 1)'(phase_step_reg);
    assign pos_adv = pos_sum[svm_pkg::POS_W] ? '1 : pos_sum[svm_pkg::POS_W-1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        if (in_acc)
        begin
            case (in_word.cmd)
                svm_pkg::CMD_START:
                begin
                    pos_next    = '0;
                    active_next = 1'b1;
                end
                svm_pkg::CMD_MIX:
                begin
                    if (voice_stop)
                        active_next = 1'b0;
                    else if (active_reg)
                        pos_next = pos_adv;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
        end
    end

    // Stereo frame f: word 2f in the even bank, 2f+1 in the odd bank, both at
    // index f. Mono frame f: bank f[0], index f/2.
    assign rd_idx = stereo_reg ? frame : {1'b0, frame[svm_pkg::FRAME_W-1:1]};
    assign addr_l = stereo_reg ? {frame, 1'b0} : {1'b0, frame};
    assign addr_r = {frame, 1'b1};
    assign rd_en  = in_acc && is_mix;

    assign wr_ok   = (32'(in_word.sample_addr) < 32'(STORE_WORDS));
    assign even_we = in_acc && is_write && wr_ok && !in_word.sample_addr[0];
    assign odd_we  = in_acc && is_write && wr_ok &&  in_word.sample_addr[0];

    svm_ram #(
        .WIDTH (16),
        .DEPTH (EVEN_DEPTH)
    ) u_even_bank (
        .clk     (clk),
        .wr_en   (even_we),
        .wr_addr (EIDX_W'(in_word.sample_addr[15:1])),
        .wr_data (in_word.sample_data),
        .rd_en   (rd_en),
        .rd_addr (EIDX_W'(rd_idx)),
        .rd_data (even_data)
    );

    svm_ram #(
        .WIDTH (16),
        .DEPTH (ODD_DEPTH)
    ) u_odd_bank (
        .clk     (clk),
        .wr_en   (odd_we),
        .wr_addr (OIDX_W'(in_word.sample_addr[15:1])),
        .wr_data (in_word.sample_data),
        .rd_en   (rd_en),
        .rd_addr (OIDX_W'(rd_idx)),
        .rd_data (odd_data)
    );

    // control travelling alongside the store read
    always_comb
    begin
        s1_next.valid    = rd_en;
        s1_next.play     = active_reg && !voice_stop;
        s1_next.stereo   = stereo_reg;
        s1_next.mono_odd = frame[0];
        s1_next.l_ok     = (32'(addr_l) < 32'(STORE_WORDS));
        s1_next.r_ok     = (32'(addr_r) < 32'(STORE_WORDS));
        s1_next.bus_l    = in_word.mix_left;
        s1_next.bus_r    = in_word.mix_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else
            s1_reg <= s1_next;
    end

    svm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1_reg),
        .even_data (even_data),
        .odd_data  (odd_data),
        .gain      (volume_gain_reg),
        .res_valid (res_valid),
        .res       (res_word)
    );

    svm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_word  (res_word),
        .pop        (pop),
        .head_valid (out_valid),
        .head_word  (out_word)
    );

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        occ_next = occ_reg;
        if (rd_en && !pop)
            occ_next = occ_reg + 1'b1;
        else if (pop && !rd_en)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // credit count never exceeds the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= svm_pkg::OCC_FULL)
        else $error("result credit count above queue depth");

    // a result on the port must be covered by an outstanding credit
    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occ_reg != '0))
        else $error("result shown without an outstanding mix word");

    // start rewinds and arms the voice
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_start) |=> (active_reg && (pos_reg == '0)))
        else $error("start did not rewind the voice");

    // a looped frame plays from zero, so the position is exactly one step
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && is_mix && voice_wrap)
            |=> (pos_reg == svm_pkg::POS_W'($past(phase_step_reg))))
        else $error("loop wrap did not restart the position");

endmodule

// ----- hw/rtl/svm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/svm_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_mix: gain and saturating bus add
// Picks the source samples from the two store banks, multiplies by the
// Q4.12 gain (registered), truncates toward zero and saturates the bus sum.
// ----------------------------------------------------------------------------
module svm_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  svm_pkg::s1_t       s1,
    input  logic [15:0]        even_data,
    input  logic [15:0]        odd_data,
    input  logic [15:0]        gain,
    output logic               res_valid,
    output svm_pkg::out_t      res
);

    logic signed [15:0] samp_l;
    logic signed [15:0] samp_r;
    logic signed [32:0] prod_l_next;
    logic signed [32:0] prod_r_next;

    logic signed [32:0] prod_l_reg;
    logic signed [32:0] prod_r_reg;
    logic signed [15:0] bus_l_reg;
    logic signed [15:0] bus_r_reg;
    logic               play_reg;
    logic               valid_reg;

    // Q4.12 product back to sample scale, rounding toward zero
    function automatic logic signed [20:0] scale_q12(input logic signed [32:0] p);
        logic signed [32:0] adj;
        begin
            adj = p + (p[32] ? 33'sd4095 : 33'sd0);
            scale_q12 = adj[32:12];
        end
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] bus,
                                                  input logic signed [20:0] v);
        logic signed [21:0] sum;
        begin
            sum = 22'(bus) + 22'(v);
            if (sum > 22'sd32767)
                sat_add = 16'sh7fff;
            else if (sum < -22'sd32768)
                sat_add = 16'sh8000;
            else
                sat_add = sum[15:0];
        end
    endfunction

    // idle voice or out-of-store word reads as zero, so the bus passes through
    always_comb
    begin
        samp_l = '0;
        samp_r = '0;
        if (s1.play)
        begin
            if (s1.stereo)
            begin
                samp_l = s1.l_ok ? $signed(even_data) : 16'sd0;
                samp_r = s1.r_ok ? $signed(odd_data)  : 16'sd0;
            end
            else
            begin
                samp_l = s1.l_ok ? $signed(s1.mono_odd ? odd_data : even_data) : 16'sd0;
                samp_r = samp_l;
            end
        end
        prod_l_next = 33'(samp_l) * $signed({17'b0, gain});
        prod_r_next = 33'(samp_r) * $signed({17'b0, gain});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            play_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= s1.valid;
            play_reg  <= s1.play;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        bus_l_reg  <= s1.bus_l;
        bus_r_reg  <= s1.bus_r;
    end

    assign res_valid         = valid_reg;
    assign res.out_left      = sat_add(bus_l_reg, scale_q12(prod_l_reg));
    assign res.out_right     = sat_add(bus_r_reg, scale_q12(prod_r_reg));
    assign res.still_playing = play_reg;

endmodule

// ----- hw/rtl/svm_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_fifo: result queue
// Small register queue between the mix pipeline and the output channel.
// ----------------------------------------------------------------------------
module svm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  svm_pkg::out_t push_word,
    input  logic          pop,
    output logic          head_valid,
    output svm_pkg::out_t head_word
);

    svm_pkg::out_t                    mem_reg [svm_pkg::OUT_DEPTH];
    logic [svm_pkg::OUT_PTR_W-1:0]    wr_ptr_reg;
    logic [svm_pkg::OUT_PTR_W-1:0]    rd_ptr_reg;
    logic [svm_pkg::OCC_W-1:0]        count_reg;
    logic [svm_pkg::OCC_W-1:0]        count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];

endmodule

// ----- sim/tb_sample_voice_mixer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_voice_mixer_core: self-checking bench for the playback voice
// This bench sends sample writes, starts and mix words, and sometimes the
// unused code. Both sides idle and stall at random. A software model of the
// voice predicts every mix result, and each result word is checked field by
// field against those predictions, in order.
// ----------------------------------------------------------------------------
module tb_sample_voice_mixer_core;

    localparam int         STORE_WORDS  = 65536;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    // margin after the last result before touching registers
    localparam int         DRAIN_CYCLES = 8;
    localparam int         DRAIN_LIMIT  = 20000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    svm_pkg::in_t                   in_word   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    svm_pkg::out_t                  out_word;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [svm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [svm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // percentage of cycles each side sits idle; zeroed for burst stretches
    int in_idle_pct   = 38;
    int out_stall_pct = 38;

    // voice model: shadow store, position, run flag and register copies
    logic signed [15:0]          shadow_store [STORE_WORDS];
    bit                          word_written [STORE_WORDS];
    logic [svm_pkg::POS_W-1:0]   voice_pos;
    bit                          voice_on;
    logic [23:0]                 step_q;
    logic [15:0]                 gain_q;
    bit                          stereo_q;
    bit                          loop_q;
    logic [svm_pkg::FRAME_W-1:0] frames_q;

    // mix results predicted but not yet seen on the output
    svm_pkg::out_t bus_frames_due [$];

    int n_mix;
    int n_mix_playing;
    int n_write;
    int n_start;
    int n_unused;
    int n_words_sent;
    int n_cfg;
    int n_settings;
    int n_results;
    int n_mismatch;

    sample_voice_mixer_core #(
        .STORE_WORDS (STORE_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Voice model
    // ------------------------------------------------------------------------

    // Word address past the store reads as zero (stereo frames >= 32768).
    function automatic int read_word(int unsigned addr);
        if (addr >= STORE_WORDS)
            return 0;
        return int'(shadow_store[addr[15:0]]);
    endfunction

    // Q4.12 gain, truncated toward zero for negative products
    function automatic int gained(int s);
        longint p;
        p = longint'(s) * longint'(gain_q);
        if (p < 0)
            return -int'((-p) >>> 12);
        return int'(p >>> 12);
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // End of sound is judged at the start of a mix frame: wrap when looping
    // over a non-empty sound, otherwise the voice falls silent.
    function automatic void apply_end_of_sound(inout logic [svm_pkg::POS_W-1:0] pos,
                                               inout bit on);
        if (on && pos[svm_pkg::POS_W-1:16] >= frames_q)
        begin
            if (loop_q && frames_q != 0)
                pos = '0;
            else
                on = 1'b0;
        end
    endfunction

    function automatic void voice_predict(svm_pkg::in_t w);
        logic [svm_pkg::FRAME_W-1:0] f;
        int                          l;
        int                          r;
        logic [svm_pkg::POS_W:0]     next_pos;
        svm_pkg::out_t               res;
        case (w.cmd)
            svm_pkg::CMD_WRITE:
            begin
                if (w.sample_addr < STORE_WORDS)
                begin
                    shadow_store[w.sample_addr] = w.sample_data;
                    word_written[w.sample_addr] = 1'b1;
                end
            end
            svm_pkg::CMD_START:
            begin
                voice_pos = '0;
                voice_on  = 1'b1;
            end
            svm_pkg::CMD_MIX:
            begin
                apply_end_of_sound(voice_pos, voice_on);
                res.out_left      = w.mix_left;
                res.out_right     = w.mix_right;
                res.still_playing = voice_on;
                if (voice_on)
                begin
                    f = voice_pos[svm_pkg::POS_W-1:16];
                    if (stereo_q)
                    begin
                        l = gained(read_word(32'({f, 1'b0})));
                        r = gained(read_word(32'({f, 1'b1})));
                    end
                    else
                    begin
                        l = gained(read_word(32'(f)));
                        r = l;
                    end
                    res.out_left  = clip16(int'(w.mix_left) + l);
                    res.out_right = clip16(int'(w.mix_right) + r);
                    // position saturates at the top of Q17.16
                    next_pos  = {1'b0, voice_pos} + (svm_pkg::POS_W + 1)'(step_q);
                    voice_pos = next_pos[svm_pkg::POS_W] ? '1
                                                         : next_pos[svm_pkg::POS_W-1:0];
                    n_mix_playing++;
                end
                bus_frames_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Store words the next mix frame would read, without touching the state.
    function automatic int pending_reads(output int unsigned a0, output int unsigned a1);
        logic [svm_pkg::POS_W-1:0]   pos;
        bit                          on;
        logic [svm_pkg::FRAME_W-1:0] f;
        pos = voice_pos;
        on  = voice_on;
        a0  = 0;
        a1  = 0;
        apply_end_of_sound(pos, on);
        if (!on)
            return 0;
        f = pos[svm_pkg::POS_W-1:16];
        if (!stereo_q)
        begin
            a0 = 32'(f);
            return 1;
        end
        a0 = 32'({f, 1'b0});
        a1 = 32'({f, 1'b1});
        return 2;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    function automatic svm_pkg::in_t make_word(logic [1:0] cmd, logic [15:0] addr,
                                               logic [15:0] data, logic [15:0] l,
                                               logic [15:0] r);
        svm_pkg::in_t w;
        w.cmd         = cmd;
        w.sample_addr = addr;
        w.sample_data = data;
        w.mix_left    = l;
        w.mix_right   = r;
        return w;
    endfunction

    // Bus sample with the rails showing up often.
    function automatic logic [15:0] bus_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One input word: random idle first, then hold until taken. Valid is
    // only dropped by idle gaps or wait_idle; back-to-back words keep it high.
    task automatic send_word(svm_pkg::in_t w);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        voice_predict(w);
        case (w.cmd)
            svm_pkg::CMD_WRITE: n_write++;
            svm_pkg::CMD_START: n_start++;
            svm_pkg::CMD_MIX:   n_mix++;
            default:            n_unused++;
        endcase
        if (w.cmd != CMD_UNUSED)
            n_words_sent++;
    endtask

    // Fields a command does not use carry random bits.
    task automatic send_sample(logic [15:0] addr, logic [15:0] data);
        send_word(make_word(svm_pkg::CMD_WRITE, addr, data, 16'($urandom), 16'($urandom)));
    endtask

    task automatic start_voice();
        send_word(make_word(svm_pkg::CMD_START, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom)));
    endtask

    task automatic fill_if_blank(int unsigned a);
        if (a < STORE_WORDS && !word_written[a[15:0]])
            send_sample(a[15:0], 16'($urandom));
    endtask

    // Never play a store word that was not written: fill it first.
    task automatic mix_frame(logic [15:0] l, logic [15:0] r);
        int unsigned a0;
        int unsigned a1;
        int          n;
        n = pending_reads(a0, a1);
        if (n > 0)
            fill_if_blank(a0);
        if (n > 1)
            fill_if_blank(a1);
        send_word(make_word(svm_pkg::CMD_MIX, 16'($urandom), 16'($urandom), l, r));
    endtask

    // Let every pending result out, then give write and start words
    // still in the pipe time to land.
    task automatic wait_idle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (bus_frames_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [svm_pkg::CFG_IDX_W-1:0] idx,
                             logic [svm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            svm_pkg::REG_PHASE_STEP:  step_q   = data;
            svm_pkg::REG_VOLUME_GAIN: gain_q   = data[15:0];
            svm_pkg::REG_STEREO:      stereo_q = data[0];
            svm_pkg::REG_LOOP:        loop_q   = data[0];
            svm_pkg::REG_FRAME_COUNT: frames_q = data[svm_pkg::FRAME_W-1:0];
            default: ;
        endcase
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New voice setting: only from idle, all five registers every time.
    task automatic setup_voice(logic [23:0] step, logic [15:0] gain, bit stereo, bit looping,
                               logic [svm_pkg::FRAME_W-1:0] frames);
        wait_idle();
        write_reg(svm_pkg::REG_PHASE_STEP, step);
        write_reg(svm_pkg::REG_VOLUME_GAIN, svm_pkg::CFG_DATA_W'(gain));
        write_reg(svm_pkg::REG_STEREO, svm_pkg::CFG_DATA_W'(stereo));
        write_reg(svm_pkg::REG_LOOP, svm_pkg::CFG_DATA_W'(looping));
        write_reg(svm_pkg::REG_FRAME_COUNT, svm_pkg::CFG_DATA_W'(frames));
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker and output stall
    // ------------------------------------------------------------------------

    task automatic flag_field(string field, logic signed [15:0] want, logic signed [15:0] got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch: result %0d %s expected %0d got %0d",
                     n_results, field, want, got);
    endtask

    always @(posedge clk)
    begin
        svm_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (bus_frames_due.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: result %0d arrived with nothing pending (word %h)",
                             n_results, out_word);
            end
            else
            begin
                want = bus_frames_due.pop_front();
                if (out_word.out_left !== want.out_left)
                    flag_field("out_left", want.out_left, out_word.out_left);
                if (out_word.out_right !== want.out_right)
                    flag_field("out_right", want.out_right, out_word.out_right);
                if (out_word.still_playing !== want.still_playing)
                    flag_field("still_playing", 16'(want.still_playing),
                               16'(out_word.still_playing));
            end
        end
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Voice never started: bus goes straight through. Also the unused code
    // with every bit set, and an empty sound with looping on.
    task automatic test_idle_passthrough();
        mix_frame(16'h7FFF, 16'h8000);
        mix_frame(16'h8000, 16'h7FFF);
        send_word(make_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        mix_frame(16'h0000, 16'hFFFF);
        setup_voice(svm_pkg::PHASE_STEP_RST, svm_pkg::VOLUME_GAIN_RST, 1'b0, 1'b1, '0);
        start_voice();
        mix_frame(16'h1234, 16'hEDCC);
    endtask

    // Max gain drives both rails; -3 and 3 check truncation toward zero.
    task automatic test_gain_and_saturation();
        setup_voice(24'd65536, 16'hFFFF, 1'b0, 1'b0, 17'd4);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'd1, 16'h8000);
        send_sample(16'd2, 16'hFFFD);
        send_sample(16'd3, 16'h0003);
        send_sample(16'hFFFF, 16'h5A5A);
        start_voice();
        mix_frame(16'h7FFF, 16'h8000);
        mix_frame(16'h8000, 16'h7FFF);
        mix_frame(16'd10, 16'hFFF6);
        mix_frame(16'd0, 16'd0);
        mix_frame(16'h4000, 16'hC000);
        // zero gain: bus unchanged but the voice still counts as playing
        setup_voice(24'd65536, 16'd0, 1'b0, 1'b0, 17'd4);
        start_voice();
        mix_frame(16'h0101, 16'hFEFE);
        // stereo pairs, gain just over unity
        setup_voice(24'd65536, 16'd4097, 1'b1, 1'b0, 17'd2);
        start_voice();
        repeat (3) mix_frame(bus_value(), bus_value());
    endtask

    task automatic test_end_of_sound();
        setup_voice(24'd65536, svm_pkg::VOLUME_GAIN_RST, 1'b0, 1'b1, 17'd3);
        start_voice();
        repeat (7) mix_frame(bus_value(), bus_value());
        // half speed, no loop: each frame twice, then the voice stops
        setup_voice(24'd32768, svm_pkg::VOLUME_GAIN_RST, 1'b0, 1'b0, 17'd2);
        start_voice();
        repeat (5) mix_frame(bus_value(), bus_value());
        start_voice();
        mix_frame(bus_value(), bus_value());
    endtask

    // Fastest step over the largest sound: stereo reads walk past the
    // top of the store and must come back as zero.
    task automatic test_far_stereo_reads();
        setup_voice(24'hFFFFFF, 16'($urandom), 1'b1, 1'b0, 17'd65536);
        start_voice();
        repeat (132) mix_frame(bus_value(), bus_value());
    endtask

    // A random setting, a start, then mostly mix frames with some noise.
    task automatic run_random_phase(int n_words);
        logic [23:0]                 step;
        logic [15:0]                 gain;
        logic [svm_pkg::FRAME_W-1:0] frames;
        int                          roll;
        case ($urandom_range(0, 4))
            0:       step = 24'd0;
            1:       step = 24'hFFFFFF;
            2:       step = 24'd65536;
            3:       step = 24'($urandom_range(1, 196608));
            default: step = 24'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       gain = 16'd0;
            1:       gain = 16'hFFFF;
            2:       gain = svm_pkg::VOLUME_GAIN_RST;
            default: gain = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       frames = '0;
            1:       frames = 17'd1;
            2:       frames = 17'd65536;
            3, 4:    frames = 17'($urandom_range(2, 48));
            default: frames = 17'($urandom_range(1, 65536));
        endcase
        setup_voice(step, gain, 1'($urandom), 1'($urandom), frames);
        start_voice();
        repeat (n_words)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                send_sample(16'($urandom), 16'($urandom));
            else if (roll < 10)
                start_voice();
            else if (roll < 13)
                send_word(make_word(CMD_UNUSED, 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom)));
            else
                mix_frame(bus_value(), bus_value());
        end
    endtask

    task automatic test_random_playback();
        int first;
        first = n_words_sent;
        while (n_words_sent - first < 50)
            run_random_phase($urandom_range(10, 25));
    endtask

    // No idling at all, then a receiver that rarely takes results so the
    // result queue fills and input back-pressure kicks in.
    task automatic test_back_to_back();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_phase(30);
        run_random_phase(30);
        out_stall_pct = 90;
        run_random_phase(24);
        wait_idle();
        in_idle_pct   = 38;
        out_stall_pct = 38;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        voice_pos = '0;
        voice_on  = 1'b0;
        step_q    = svm_pkg::PHASE_STEP_RST;
        gain_q    = svm_pkg::VOLUME_GAIN_RST;
        stereo_q  = 1'b0;
        loop_q    = 1'b0;
        frames_q  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_passthrough();
        test_gain_and_saturation();
        test_end_of_sound();
        test_far_stereo_reads();
        test_random_playback();
        test_back_to_back();

        wait_idle();
        $display("covered %0d mix frames (%0d with the voice sounding), %0d sample writes,",
                 n_mix, n_mix_playing, n_write);
        $display("%0d starts, %0d unused-code words, %0d voice settings (%0d register writes), %0d results checked",
                 n_start, n_unused, n_settings, n_cfg, n_results);
        if (n_mismatch == 0 && bus_frames_due.size() == 0)
        begin
            $display("PASS sample_voice_mixer_core");
        end
        else
        begin
            if (bus_frames_due.size() != 0)
                $display("%0d mix results never arrived", bus_frames_due.size());
            $display("%0d mismatches", n_mismatch);
            $display("FAIL sample_voice_mixer_core");
        end
        $finish;
    end

    // Watchdog: the whole run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("timed out with %0d results pending", bus_frames_due.size());
        $display("FAIL sample_voice_mixer_core");
        $finish;
    end

endmodule
